>>> sv/ir_wlr_pkg.sv
// Package for the IR waveform learn/replay unit.
// Holds request mode codes, configuration register indexes, fixed widths, the end mark and reset values.
// No dependencies.
package ir_wlr_pkg;

  localparam int TICK_W    = 16;
  localparam int IDX_W     = 8;
  localparam int OVF_W     = 8;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DAT_W = 16;

  localparam logic [TICK_W-1:0] END_MARK            = 16'hFFFF;
  localparam logic [TICK_W-1:0] MIN_FIRST_PULSE_RST = 16'd1250;
  localparam logic [OVF_W-1:0]  TIMEOUT_OVF_RST     = 8'h01;

  typedef enum logic [2:0] {
    MODE_ARM      = 3'd0,
    MODE_EDGE     = 3'd1,
    MODE_OVERFLOW = 3'd2,
    MODE_LOAD     = 3'd3,
    MODE_START_TX = 3'd4,
    MODE_COMPARE  = 3'd5,
    MODE_READ     = 3'd6,
    MODE_RELEASE  = 3'd7
  } mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MIN_FIRST_PULSE = 1'b0,
    CFG_TIMEOUT_OVF     = 1'b1
  } cfg_reg_t;

endpackage

>>> sv/ir_waveform_learn_replay_unit.sv
// Top level of the IR waveform learn/replay unit.
// The result is registered: a request passes the request register, then the result register;
// throughput one request per cycle while the result channel does not stall.
// Stage one registers the request and the store read; stage two updates state and
// loads the result register. The store read port limits the design to one access per request.
// Reset clears all control state and restores the configuration defaults; the interval
// store is not cleared and its entries are undefined until written.
module ir_waveform_learn_replay_unit #(
  parameter int WAVE_DEPTH = 256
) (
  input  logic                                 clk,
  input  logic                                 rst,
  // request channel
  input  logic                                 req_valid,
  output logic                                 req_stall,
  input  logic [2:0]                           mode,
  input  logic [ir_wlr_pkg::TICK_W-1:0]        timestamp,
  input  logic [ir_wlr_pkg::IDX_W-1:0]         entry_index,
  input  logic [ir_wlr_pkg::TICK_W-1:0]        entry_value,
  // result channel
  output logic                                 res_valid,
  input  logic                                 res_stall,
  output logic [ir_wlr_pkg::TICK_W-1:0]        compare_value,
  output logic                                 carrier_enable,
  output logic                                 tx_running,
  output logic                                 rx_finished,
  output logic [ir_wlr_pkg::IDX_W-1:0]         entry_count,
  output logic [ir_wlr_pkg::TICK_W-1:0]        read_value,
  output logic                                 accepted,
  // configuration channel
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [ir_wlr_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [ir_wlr_pkg::CFG_DAT_W-1:0]     cfg_data
);

  localparam int AW = (WAVE_DEPTH > 1) ? $clog2(WAVE_DEPTH) : 1;
  localparam logic [ir_wlr_pkg::IDX_W-1:0] LAST_IDX = ir_wlr_pkg::IDX_W'(WAVE_DEPTH - 1);
  localparam logic [ir_wlr_pkg::IDX_W:0]   DEPTH_LIM = (ir_wlr_pkg::IDX_W + 1)'(WAVE_DEPTH);

  // ---------------------------------------------------------------------------
  // Configuration registers: the user must write them only while the unit is idle; not enforced here.
  // ---------------------------------------------------------------------------
  logic [ir_wlr_pkg::TICK_W-1:0] min_first_pulse;
  logic [ir_wlr_pkg::OVF_W-1:0]  timeout_overflows;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_first_pulse   <= ir_wlr_pkg::MIN_FIRST_PULSE_RST;
      timeout_overflows <= ir_wlr_pkg::TIMEOUT_OVF_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (ir_wlr_pkg::cfg_reg_t'(cfg_index))
        ir_wlr_pkg::CFG_MIN_FIRST_PULSE: min_first_pulse   <= cfg_data;
        ir_wlr_pkg::CFG_TIMEOUT_OVF:     timeout_overflows <= cfg_data[ir_wlr_pkg::OVF_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Stage one: request register. The store read for the request is issued at
  // accept, so the data arrives together with the request.
  // ---------------------------------------------------------------------------
  logic                          exec_valid;
  ir_wlr_pkg::mode_t             exec_mode;
  logic [ir_wlr_pkg::TICK_W-1:0] exec_ts;
  logic [ir_wlr_pkg::IDX_W-1:0]  exec_idx;
  logic [ir_wlr_pkg::TICK_W-1:0] exec_val;
  logic                          exec_fire;
  logic                          req_take;

  assign exec_fire = exec_valid && (!res_valid || !res_stall);
  assign req_stall = exec_valid && !exec_fire;
  assign req_take  = req_valid && !req_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      exec_valid <= 1'b0;
    end else if (req_take) begin
      exec_valid <= 1'b1;
    end else if (exec_fire) begin
      exec_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req_take) begin
      exec_mode <= ir_wlr_pkg::mode_t'(mode);
      exec_ts   <= timestamp;
      exec_idx  <= entry_index;
      exec_val  <= entry_value;
    end
  end

  // ---------------------------------------------------------------------------
  // Architectural state.
  // ---------------------------------------------------------------------------
  logic [ir_wlr_pkg::IDX_W-1:0]  wave_index,      wave_index_next;
  logic                          rx_started,      rx_started_next;
  logic                          rx_done,         rx_done_next;
  logic                          capture_enabled, capture_enabled_next;
  logic [ir_wlr_pkg::TICK_W-1:0] last_edge_time,  last_edge_time_next;
  logic [ir_wlr_pkg::OVF_W-1:0]  overflow_count,  overflow_count_next;
  logic [ir_wlr_pkg::OVF_W-1:0]  overflow_at_edge, overflow_at_edge_next;
  logic [ir_wlr_pkg::TICK_W-1:0] compare_acc,     compare_acc_next;
  logic                          tx_active,       tx_active_next;
  logic                          carrier_state,   carrier_state_next;
  // Shadow copy of store entry zero: the edge check reads it alongside the write.
  logic [ir_wlr_pkg::TICK_W-1:0] first_interval,  first_interval_next;

  logic [ir_wlr_pkg::TICK_W-1:0] store_rd_data;
  logic                          store_we;
  logic [AW-1:0]                 store_waddr;
  logic [ir_wlr_pkg::TICK_W-1:0] store_wdata;
  logic [AW-1:0]                 store_raddr;

  logic [ir_wlr_pkg::TICK_W-1:0] read_value_next;
  logic                          accepted_next;

  // Stage two: one request's full effect, between request register and result register.
  always_comb begin
    logic [ir_wlr_pkg::TICK_W-1:0] diff;
    logic [ir_wlr_pkg::TICK_W-1:0] check_val;
    logic [ir_wlr_pkg::OVF_W-1:0]  ovf_inc;
    logic [ir_wlr_pkg::OVF_W-1:0]  ovf_gap;
    logic                          idx_in_range;

    wave_index_next       = wave_index;
    rx_started_next       = rx_started;
    rx_done_next          = rx_done;
    capture_enabled_next  = capture_enabled;
    last_edge_time_next   = last_edge_time;
    overflow_count_next   = overflow_count;
    overflow_at_edge_next = overflow_at_edge;
    compare_acc_next      = compare_acc;
    tx_active_next        = tx_active;
    carrier_state_next    = carrier_state;
    first_interval_next   = first_interval;
    store_we              = 1'b0;
    store_waddr           = wave_index[AW-1:0];
    store_wdata           = exec_val;
    read_value_next       = '0;
    accepted_next         = 1'b0;

    diff         = exec_ts - last_edge_time;
    check_val    = (wave_index == '0) ? diff : first_interval;
    ovf_inc      = overflow_count + 1'b1;
    ovf_gap      = ovf_inc - overflow_at_edge;
    idx_in_range = {1'b0, exec_idx} < DEPTH_LIM;

    if (exec_valid) begin
      unique case (exec_mode)
        ir_wlr_pkg::MODE_ARM: begin
          rx_started_next      = 1'b0;
          wave_index_next      = '0;
          capture_enabled_next = 1'b1;
        end
        ir_wlr_pkg::MODE_EDGE: begin
          if (capture_enabled) begin
            overflow_at_edge_next = overflow_count;
            if (rx_started) begin
              store_we    = 1'b1;
              store_waddr = wave_index[AW-1:0];
              store_wdata = diff;
              if (wave_index == '0) begin
                first_interval_next = diff;
              end
              if (check_val > min_first_pulse) begin
                // Advance, then hold at the last entry when the store is full.
                if (wave_index < LAST_IDX) begin
                  wave_index_next = wave_index + 1'b1;
                end
              end else begin
                rx_started_next = 1'b0;
              end
            end else begin
              rx_started_next = 1'b1;
            end
            last_edge_time_next = exec_ts;
          end
        end
        ir_wlr_pkg::MODE_OVERFLOW: begin
          overflow_count_next = ovf_inc;
          if (rx_started && (ovf_gap > timeout_overflows)) begin
            capture_enabled_next = 1'b0;
            rx_started_next      = 1'b0;
            rx_done_next         = 1'b1;
          end
        end
        ir_wlr_pkg::MODE_LOAD: begin
          if (idx_in_range) begin
            store_we    = 1'b1;
            store_waddr = exec_idx[AW-1:0];
            store_wdata = exec_val;
            if (exec_idx == '0) begin
              first_interval_next = exec_val;
            end
          end
        end
        ir_wlr_pkg::MODE_START_TX: begin
          wave_index_next = '0;
          tx_active_next  = 1'b1;
        end
        ir_wlr_pkg::MODE_COMPARE: begin
          if (tx_active) begin
            if (store_rd_data == ir_wlr_pkg::END_MARK) begin
              tx_active_next     = 1'b0;
              carrier_state_next = 1'b0;
            end else begin
              compare_acc_next   = compare_acc + store_rd_data;
              // Carrier bursts sit at even positions, gaps at odd ones.
              carrier_state_next = ~wave_index[0];
              if (wave_index < LAST_IDX) begin
                wave_index_next = wave_index + 1'b1;
              end
            end
          end
        end
        ir_wlr_pkg::MODE_READ: begin
          if (idx_in_range) begin
            read_value_next = store_rd_data;
          end
        end
        ir_wlr_pkg::MODE_RELEASE: begin
          if (rx_done) begin
            wave_index_next = '0;
            rx_done_next    = 1'b0;
            accepted_next   = 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // Read address for the incoming request: a compare reads at the replay position
  // that the request in stage two leaves behind; everything else at entry_index.
  always_comb begin
    if (ir_wlr_pkg::mode_t'(mode) == ir_wlr_pkg::MODE_COMPARE) begin
      store_raddr = wave_index_next[AW-1:0];
    end else begin
      store_raddr = entry_index[AW-1:0];
    end
  end

  ir_wlr_store #(
    .DEPTH (WAVE_DEPTH),
    .AW    (AW)
  ) u_store (
    .clk     (clk),
    .wr_en   (store_we && exec_fire),
    .wr_addr (store_waddr),
    .wr_data (store_wdata),
    .rd_en   (req_take),
    .rd_addr (store_raddr),
    .rd_data (store_rd_data)
  );

  // Commit state when the request leaves stage two.
  always_ff @(posedge clk) begin
    if (rst) begin
      wave_index       <= '0;
      rx_started       <= 1'b0;
      rx_done          <= 1'b0;
      capture_enabled  <= 1'b0;
      last_edge_time   <= '0;
      overflow_count   <= '0;
      overflow_at_edge <= '0;
      compare_acc      <= '0;
      tx_active        <= 1'b0;
      carrier_state    <= 1'b0;
      first_interval   <= '0;
    end else if (exec_fire) begin
      wave_index       <= wave_index_next;
      rx_started       <= rx_started_next;
      rx_done          <= rx_done_next;
      capture_enabled  <= capture_enabled_next;
      last_edge_time   <= last_edge_time_next;
      overflow_count   <= overflow_count_next;
      overflow_at_edge <= overflow_at_edge_next;
      compare_acc      <= compare_acc_next;
      tx_active        <= tx_active_next;
      carrier_state    <= carrier_state_next;
      first_interval   <= first_interval_next;
    end
  end

  // ---------------------------------------------------------------------------
  // Result register: hold while stalled, load when stage two fires.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (exec_fire) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (exec_fire) begin
      compare_value  <= compare_acc_next;
      carrier_enable <= carrier_state_next;
      tx_running     <= tx_active_next;
      rx_finished    <= rx_done_next;
      entry_count    <= wave_index_next;
      read_value     <= read_value_next;
      accepted       <= accepted_next;
    end
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_index_bounded: assert property (@(posedge clk) disable iff (rst)
    wave_index <= LAST_IDX)
    else $error("replay/capture index beyond store depth");

  a_started_needs_capture: assert property (@(posedge clk) disable iff (rst)
    rx_started |-> capture_enabled)
    else $error("capture started while capture disabled");

  a_release_clears_done: assert property (@(posedge clk) disable iff (rst)
    (res_valid && accepted) |-> (!rx_finished && (entry_count == '0)))
    else $error("release result left capture done or index set");

  a_stall_only_when_busy: assert property (@(posedge clk) disable iff (rst)
    req_stall |-> (exec_valid && res_valid && res_stall))
    else $error("request stalled without downstream backpressure");

  a_fire_loads_result: assert property (@(posedge clk) disable iff (rst)
    exec_fire |=> res_valid)
    else $error("stage two fired but no result presented");

endmodule

>>> sv/ir_wlr_store.sv
// Interval store of the IR waveform learn/replay unit.
// One write and one registered read per cycle, with write-to-read bypass.
// Depends on ir_wlr_pkg for the interval width.
module ir_wlr_store #(
  parameter int DEPTH = 256,
  parameter int AW    = 8
) (
  input  logic                             clk,
  input  logic                             wr_en,
  input  logic [AW-1:0]                    wr_addr,
  input  logic [ir_wlr_pkg::TICK_W-1:0]    wr_data,
  input  logic                             rd_en,
  input  logic [AW-1:0]                    rd_addr,
  output logic [ir_wlr_pkg::TICK_W-1:0]    rd_data
);

  logic [ir_wlr_pkg::TICK_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Forward a same-cycle write so the next request sees fresh data.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      if (wr_en && (wr_addr == rd_addr)) begin
        rd_data <= wr_data;
      end else begin
        rd_data <= mem[rd_addr];
      end
    end
  end

endmodule

>>> tb/sv/ir_wlr_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the IR waveform learn/replay unit: watches the request, result and
// configuration channels, predicts every result and compares it field by field.
// Depends on ir_wlr_pkg.
module ir_wlr_checker #(
  parameter int WAVE_DEPTH = 256
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             req_valid,
  input  logic                             req_stall,
  input  logic [2:0]                       mode,
  input  logic [ir_wlr_pkg::TICK_W-1:0]    timestamp,
  input  logic [ir_wlr_pkg::IDX_W-1:0]     entry_index,
  input  logic [ir_wlr_pkg::TICK_W-1:0]    entry_value,
  input  logic                             res_valid,
  input  logic                             res_stall,
  input  logic [ir_wlr_pkg::TICK_W-1:0]    compare_value,
  input  logic                             carrier_enable,
  input  logic                             tx_running,
  input  logic                             rx_finished,
  input  logic [ir_wlr_pkg::IDX_W-1:0]     entry_count,
  input  logic [ir_wlr_pkg::TICK_W-1:0]    read_value,
  input  logic                             accepted,
  input  logic                             cfg_valid,
  input  logic                             cfg_ready,
  input  logic [ir_wlr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ir_wlr_pkg::CFG_DAT_W-1:0] cfg_data,
  output logic [31:0]                      fail_count,
  output logic [31:0]                      pending
);

  typedef struct {
    logic [ir_wlr_pkg::TICK_W-1:0] cmp;
    logic                          carrier;
    logic                          running;
    logic                          finished;
    logic [ir_wlr_pkg::IDX_W-1:0]  count;
    logic [ir_wlr_pkg::TICK_W-1:0] rdval;
    logic                          acc;
  } ir_result_t;

  // Shadow copy of the block state and its two registers
  logic [ir_wlr_pkg::TICK_W-1:0] stored_ticks [WAVE_DEPTH];
  logic [ir_wlr_pkg::IDX_W-1:0]  slot;
  logic                          first_seen;
  logic                          learn_done;
  logic                          capturing;
  logic [ir_wlr_pkg::TICK_W-1:0] last_stamp;
  logic [ir_wlr_pkg::OVF_W-1:0]  ovf_ticks;
  logic [ir_wlr_pkg::OVF_W-1:0]  ovf_mark;
  logic [ir_wlr_pkg::TICK_W-1:0] cmp_sum;
  logic                          replaying;
  logic                          burst_on;
  logic [ir_wlr_pkg::TICK_W-1:0] min_pulse;
  logic [ir_wlr_pkg::OVF_W-1:0]  ovf_limit;

  ir_result_t waiting_results [$];
  int n_fail = 0;
  int n_wait = 0;

  assign fail_count = n_fail;
  assign pending    = n_wait;

  initial begin
    foreach (stored_ticks[i]) stored_ticks[i] = '0;
  end

  function automatic void step_slot();
    if (slot < WAVE_DEPTH - 1) slot = slot + 1'b1;
  endfunction

  function automatic ir_result_t predict_step(ir_wlr_pkg::mode_t m,
                                              logic [ir_wlr_pkg::TICK_W-1:0] ts,
                                              logic [ir_wlr_pkg::IDX_W-1:0] idx,
                                              logic [ir_wlr_pkg::TICK_W-1:0] val);
    ir_result_t r;
    logic [ir_wlr_pkg::TICK_W-1:0] tick;
    logic [ir_wlr_pkg::OVF_W-1:0]  gap;
    int pos;
    pos = (slot < WAVE_DEPTH) ? slot : WAVE_DEPTH - 1;
    r.rdval = '0;
    r.acc   = 1'b0;
    case (m)
      ir_wlr_pkg::MODE_ARM: begin
        first_seen = 1'b0;
        slot       = '0;
        capturing  = 1'b1;
      end
      ir_wlr_pkg::MODE_EDGE: begin
        if (capturing) begin
          ovf_mark = ovf_ticks;
          if (first_seen) begin
            stored_ticks[pos] = ts - last_stamp;
            if (stored_ticks[0] > min_pulse) step_slot();
            else first_seen = 1'b0;
          end else begin
            first_seen = 1'b1;
          end
          last_stamp = ts;
        end
      end
      ir_wlr_pkg::MODE_OVERFLOW: begin
        ovf_ticks = ovf_ticks + 1'b1;
        gap = ovf_ticks - ovf_mark;
        if (first_seen && gap > ovf_limit) begin
          capturing  = 1'b0;
          first_seen = 1'b0;
          learn_done = 1'b1;
        end
      end
      ir_wlr_pkg::MODE_LOAD: begin
        if (idx < WAVE_DEPTH) stored_ticks[idx] = val;
      end
      ir_wlr_pkg::MODE_START_TX: begin
        slot      = '0;
        replaying = 1'b1;
      end
      ir_wlr_pkg::MODE_COMPARE: begin
        if (replaying) begin
          tick = stored_ticks[pos];
          if (tick == ir_wlr_pkg::END_MARK) begin
            replaying = 1'b0;
            burst_on  = 1'b0;
          end else begin
            cmp_sum  = cmp_sum + tick;
            burst_on = ~slot[0];
            step_slot();
          end
        end
      end
      ir_wlr_pkg::MODE_READ: begin
        if (idx < WAVE_DEPTH) r.rdval = stored_ticks[idx];
      end
      default: begin
        if (learn_done) begin
          slot       = '0;
          learn_done = 1'b0;
          r.acc      = 1'b1;
        end
      end
    endcase
    r.cmp      = cmp_sum;
    r.carrier  = burst_on;
    r.running  = replaying;
    r.finished = learn_done;
    r.count    = slot;
    return r;
  endfunction

  function automatic void field_chk(string tag, logic [ir_wlr_pkg::TICK_W-1:0] want,
                                    logic [ir_wlr_pkg::TICK_W-1:0] got);
    if (want !== got) begin
      n_fail++;
      $display("%0t: %s mismatch, expected %h, got %h", $time, tag, want, got);
    end
  endfunction

  always @(posedge clk) begin : watch
    ir_result_t want;
    if (rst) begin
      slot       = '0;
      first_seen = 1'b0;
      learn_done = 1'b0;
      capturing  = 1'b0;
      last_stamp = '0;
      ovf_ticks  = '0;
      ovf_mark   = '0;
      cmp_sum    = '0;
      replaying  = 1'b0;
      burst_on   = 1'b0;
      min_pulse  = ir_wlr_pkg::MIN_FIRST_PULSE_RST;
      ovf_limit  = ir_wlr_pkg::TIMEOUT_OVF_RST;
      waiting_results.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (ir_wlr_pkg::cfg_reg_t'(cfg_index))
          ir_wlr_pkg::CFG_MIN_FIRST_PULSE: min_pulse = cfg_data;
          ir_wlr_pkg::CFG_TIMEOUT_OVF:     ovf_limit = cfg_data[ir_wlr_pkg::OVF_W-1:0];
          default: ;
        endcase
      end
      if (req_valid && !req_stall)
        waiting_results.push_back(predict_step(ir_wlr_pkg::mode_t'(mode), timestamp,
                                               entry_index, entry_value));
      if (res_valid && !res_stall) begin
        if (waiting_results.size() == 0) begin
          n_fail++;
          $display("%0t: result arrived with no request outstanding", $time);
        end else begin
          want = waiting_results.pop_front();
          field_chk("compare_value", want.cmp, compare_value);
          field_chk("carrier_enable", ir_wlr_pkg::TICK_W'(want.carrier),
                    ir_wlr_pkg::TICK_W'(carrier_enable));
          field_chk("tx_running", ir_wlr_pkg::TICK_W'(want.running),
                    ir_wlr_pkg::TICK_W'(tx_running));
          field_chk("rx_finished", ir_wlr_pkg::TICK_W'(want.finished),
                    ir_wlr_pkg::TICK_W'(rx_finished));
          field_chk("entry_count", ir_wlr_pkg::TICK_W'(want.count),
                    ir_wlr_pkg::TICK_W'(entry_count));
          field_chk("read_value", want.rdval, read_value);
          field_chk("accepted", ir_wlr_pkg::TICK_W'(want.acc),
                    ir_wlr_pkg::TICK_W'(accepted));
        end
      end
    end
    n_wait = waiting_results.size();
  end

endmodule

>>> tb/sv/tb_top.sv
`timescale 1ns / 1ps
// Top of the IR waveform learn/replay testbench: clock, reset, request and configuration
// stimulus, and the verdict. Depends on ir_wlr_pkg, the unit and ir_wlr_checker.
module tb_top;

  logic                                clk         = 1'b0;
  logic                                rst         = 1'b1;
  logic                                req_valid   = 1'b0;
  logic                                req_stall;
  logic [2:0]                          mode        = '0;
  logic [ir_wlr_pkg::TICK_W-1:0]       timestamp   = '0;
  logic [ir_wlr_pkg::IDX_W-1:0]        entry_index = '0;
  logic [ir_wlr_pkg::TICK_W-1:0]       entry_value = '0;
  logic                                res_valid;
  logic                                res_stall   = 1'b0;
  logic [ir_wlr_pkg::TICK_W-1:0]       compare_value;
  logic                                carrier_enable;
  logic                                tx_running;
  logic                                rx_finished;
  logic [ir_wlr_pkg::IDX_W-1:0]        entry_count;
  logic [ir_wlr_pkg::TICK_W-1:0]       read_value;
  logic                                accepted;
  logic                                cfg_valid   = 1'b0;
  logic                                cfg_ready;
  logic [ir_wlr_pkg::CFG_IDX_W-1:0]    cfg_index   = '0;
  logic [ir_wlr_pkg::CFG_DAT_W-1:0]    cfg_data    = '0;
  logic [31:0]                         fails;
  logic [31:0]                         pending;

  // Idle rates in percent for the request sender and the result receiver
  int snd_idle_pct  = 13;
  int rcv_stall_pct = 76;
  int reqs_sent     = 0;

  // Register values last written, used to shape capture sequences
  logic [ir_wlr_pkg::TICK_W-1:0] cur_min  = ir_wlr_pkg::MIN_FIRST_PULSE_RST;
  logic [ir_wlr_pkg::OVF_W-1:0]  cur_ovf  = ir_wlr_pkg::TIMEOUT_OVF_RST;
  logic [ir_wlr_pkg::TICK_W-1:0] tick_now = '0;

  ir_waveform_learn_replay_unit DUT (.*);

  ir_wlr_checker chk (
    .clk, .rst, .req_valid, .req_stall, .mode, .timestamp, .entry_index, .entry_value,
    .res_valid, .res_stall, .compare_value, .carrier_enable, .tx_running, .rx_finished,
    .entry_count, .read_value, .accepted, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .fail_count(fails), .pending(pending)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Run limit: far beyond the slowest correct run with both sides stalling hard
  initial begin
    #3_000_000;
    $display("tb_top NOT OK");
    $finish;
  end

  // Receiver back-pressure: redraw the stall every cycle at the falling edge
  always @(negedge clk) begin
    res_stall = !rst && ($urandom_range(0, 99) < rcv_stall_pct);
  end

  function automatic logic [ir_wlr_pkg::TICK_W-1:0] rnd16();
    return ir_wlr_pkg::TICK_W'($urandom);
  endfunction

  function automatic logic [ir_wlr_pkg::IDX_W-1:0] rnd8();
    return ir_wlr_pkg::IDX_W'($urandom);
  endfunction

  // Present one request and hold it until the block takes it. Valid stays high into the
  // next request, so it only drops on a sender idle cycle or when a drain starts.
  task automatic send_req(input ir_wlr_pkg::mode_t m,
                          input logic [ir_wlr_pkg::TICK_W-1:0] ts,
                          input logic [ir_wlr_pkg::IDX_W-1:0] idx,
                          input logic [ir_wlr_pkg::TICK_W-1:0] val);
    @(negedge clk);
    while ($urandom_range(0, 99) < snd_idle_pct) begin
      req_valid = 1'b0;
      @(negedge clk);
    end
    req_valid   = 1'b1;
    mode        = m;
    timestamp   = ts;
    entry_index = idx;
    entry_value = val;
    do @(posedge clk); while (req_stall);
    reqs_sent++;
  endtask

  // Drop valid and hold off until every outstanding result is back, then let the
  // pipeline settle.
  task automatic drain();
    @(negedge clk);
    req_valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Register write; only called while the block is drained
  task automatic write_cfg(input ir_wlr_pkg::cfg_reg_t r,
                           input logic [ir_wlr_pkg::CFG_DAT_W-1:0] d);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = r;
    cfg_data  = d;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
    if (r == ir_wlr_pkg::CFG_MIN_FIRST_PULSE) cur_min = d;
    else cur_ovf = d[ir_wlr_pkg::OVF_W-1:0];
  endtask

  // First interval of a capture: mostly long enough to pass, sometimes too short
  function automatic logic [ir_wlr_pkg::TICK_W-1:0] first_gap();
    if (cur_min < ir_wlr_pkg::END_MARK && $urandom_range(0, 99) < 85) begin
      if (cur_min > 16'd63534) return cur_min + 16'd1;
      return cur_min + 16'd1 + ir_wlr_pkg::TICK_W'($urandom_range(0, 2000));
    end
    return ir_wlr_pkg::TICK_W'($urandom_range(0, cur_min));
  endfunction

  function automatic logic [ir_wlr_pkg::TICK_W-1:0] next_gap();
    if ($urandom_range(0, 99) < 60) return ir_wlr_pkg::TICK_W'($urandom_range(50, 3000));
    return ir_wlr_pkg::TICK_W'($urandom_range(0, 65534));
  endfunction

  // Terminate the stored waveform at end_at, start a replay and step it n_cmp times
  task automatic play_back(input int end_at, input int n_cmp);
    if (end_at < 256)
      send_req(ir_wlr_pkg::MODE_LOAD, rnd16(), ir_wlr_pkg::IDX_W'(end_at),
               ir_wlr_pkg::END_MARK);
    send_req(ir_wlr_pkg::MODE_START_TX, rnd16(), rnd8(), rnd16());
    repeat (n_cmp) send_req(ir_wlr_pkg::MODE_COMPARE, rnd16(), rnd8(), rnd16());
  endtask

  // Well-formed capture: arm, a train of edges, then overflows that time out for a
  // limit below 12. The noisy flavor adds stray overflows, reads back, releases, replays.
  task automatic learn_burst(input int n_edges, input bit noisy);
    int n_ovf;
    tick_now = rnd16();
    send_req(ir_wlr_pkg::MODE_ARM, rnd16(), rnd8(), rnd16());
    send_req(ir_wlr_pkg::MODE_EDGE, tick_now, rnd8(), rnd16());
    for (int i = 1; i < n_edges; i++) begin
      tick_now = tick_now + ((i == 1) ? first_gap() : next_gap());
      send_req(ir_wlr_pkg::MODE_EDGE, tick_now, rnd8(), rnd16());
      if (noisy && $urandom_range(0, 9) == 0)
        send_req(ir_wlr_pkg::MODE_OVERFLOW, rnd16(), rnd8(), rnd16());
    end
    n_ovf = (cur_ovf < 12) ? cur_ovf + 1 : $urandom_range(1, 12);
    repeat (n_ovf) send_req(ir_wlr_pkg::MODE_OVERFLOW, rnd16(), rnd8(), rnd16());
    if (noisy) begin
      repeat ($urandom_range(0, 3))
        send_req(ir_wlr_pkg::MODE_READ, rnd16(),
                 ir_wlr_pkg::IDX_W'($urandom_range(0, n_edges)), rnd16());
      if ($urandom_range(0, 9) != 0)
        send_req(ir_wlr_pkg::MODE_RELEASE, rnd16(), rnd8(), rnd16());
      if ($urandom_range(0, 9) < 7) play_back(n_edges - 1, n_edges + $urandom_range(0, 2));
    end
  endtask

  // Short hand-loaded waveform, replayed to (and sometimes past) its end mark
  task automatic replay_burst();
    int k;
    k = $urandom_range(0, 15);
    for (int j = 0; j < k; j++) begin
      if ($urandom_range(0, 1) != 0)
        send_req(ir_wlr_pkg::MODE_LOAD, rnd16(), ir_wlr_pkg::IDX_W'(j),
                 ir_wlr_pkg::TICK_W'($urandom_range(0, 65534)));
    end
    play_back(k, k + $urandom_range(0, 3));
  endtask

  task automatic noise_item();
    logic [ir_wlr_pkg::TICK_W-1:0] val;
    case ($urandom_range(0, 7))
      0:       val = ir_wlr_pkg::END_MARK;
      1:       val = '0;
      default: val = rnd16();
    endcase
    send_req(ir_wlr_pkg::mode_t'($urandom_range(0, 7)), rnd16(), rnd8(), val);
  endtask

  task automatic run_phase(input int n_reqs);
    int stop;
    int pick;
    stop = reqs_sent + n_reqs;
    while (reqs_sent < stop) begin
      pick = $urandom_range(0, 99);
      if (pick < 30) learn_burst($urandom_range(2, 12), 1'b1);
      else if (pick < 55) replay_burst();
      else if (pick < 58) drain();
      else noise_item();
    end
  endtask

  initial begin
    // Hold reset from the start, release it at a falling edge
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Fill the whole store first so nothing ever reads an unwritten entry
    for (int a = 0; a < 256; a++)
      send_req(ir_wlr_pkg::MODE_LOAD, rnd16(), ir_wlr_pkg::IDX_W'(a),
               ($urandom_range(0, 15) == 0) ? ir_wlr_pkg::END_MARK : rnd16());

    // Directed part on the reset register values
    send_req(ir_wlr_pkg::MODE_READ, 16'h0000, 8'h00, 16'h0000);
    send_req(ir_wlr_pkg::MODE_READ, 16'hFFFF, 8'hFF, 16'hFFFF);
    send_req(ir_wlr_pkg::MODE_LOAD, 16'h0000, 8'h00, 16'h0000);
    send_req(ir_wlr_pkg::MODE_LOAD, 16'hFFFF, 8'hFF, ir_wlr_pkg::END_MARK);
    send_req(ir_wlr_pkg::MODE_READ, 16'h0000, 8'h00, 16'h0000);
    send_req(ir_wlr_pkg::MODE_READ, 16'h0000, 8'hFF, 16'h0000);
    // Release with nothing captured, edge and overflow while not armed
    send_req(ir_wlr_pkg::MODE_RELEASE, 16'h0000, 8'h00, 16'h0000);
    send_req(ir_wlr_pkg::MODE_EDGE, 16'hFFFF, 8'h00, 16'h0000);
    send_req(ir_wlr_pkg::MODE_OVERFLOW, 16'h0000, 8'h00, 16'h0000);
    // Arm; first interval of exactly the minimum (across the counter wrap) restarts
    send_req(ir_wlr_pkg::MODE_ARM, 16'h0000, 8'h00, 16'h0000);
    send_req(ir_wlr_pkg::MODE_EDGE, 16'hFFFF, 8'h00, 16'h0000);
    send_req(ir_wlr_pkg::MODE_EDGE, 16'd1249, 8'h00, 16'h0000);
    send_req(ir_wlr_pkg::MODE_EDGE, 16'h1000, 8'h00, 16'h0000);
    send_req(ir_wlr_pkg::MODE_EDGE, 16'h1000 + 16'd1251, 8'h00, 16'h0000);
    send_req(ir_wlr_pkg::MODE_EDGE, 16'h1000 + 16'd1751, 8'h00, 16'h0000);
    // Second overflow after the last edge exceeds the limit of one and ends capture
    send_req(ir_wlr_pkg::MODE_OVERFLOW, 16'h0000, 8'h00, 16'h0000);
    send_req(ir_wlr_pkg::MODE_OVERFLOW, 16'h0000, 8'h00, 16'h0000);
    send_req(ir_wlr_pkg::MODE_EDGE, 16'h2000, 8'h00, 16'h0000);
    send_req(ir_wlr_pkg::MODE_READ, 16'h0000, 8'h01, 16'h0000);
    send_req(ir_wlr_pkg::MODE_RELEASE, 16'h0000, 8'h00, 16'h0000);
    send_req(ir_wlr_pkg::MODE_RELEASE, 16'h0000, 8'h00, 16'h0000);
    // Replay: two intervals, end mark, then a compare after the replay stopped
    send_req(ir_wlr_pkg::MODE_LOAD, 16'h0000, 8'h02, ir_wlr_pkg::END_MARK);
    send_req(ir_wlr_pkg::MODE_START_TX, 16'h0000, 8'h00, 16'h0000);
    repeat (4) send_req(ir_wlr_pkg::MODE_COMPARE, 16'h0000, 8'h00, 16'h0000);

    // Phase A: lowest register values, slow receiver
    drain();
    write_cfg(ir_wlr_pkg::CFG_MIN_FIRST_PULSE, 16'h0000);
    write_cfg(ir_wlr_pkg::CFG_TIMEOUT_OVF, {rnd8(), 8'h00});
    // Store full: capture past the last slot, then replay past it with no end mark
    learn_burst(268, 1'b0);
    send_req(ir_wlr_pkg::MODE_START_TX, rnd16(), rnd8(), rnd16());
    repeat (270) send_req(ir_wlr_pkg::MODE_COMPARE, rnd16(), rnd8(), rnd16());
    run_phase(300);

    // Phase B: mid-range registers, slow sender
    drain();
    snd_idle_pct  = 76;
    rcv_stall_pct = 13;
    write_cfg(ir_wlr_pkg::CFG_MIN_FIRST_PULSE,
              ir_wlr_pkg::TICK_W'($urandom_range(200, 3000)));
    write_cfg(ir_wlr_pkg::CFG_TIMEOUT_OVF,
              {rnd8(), ir_wlr_pkg::OVF_W'($urandom_range(1, 4))});
    run_phase(500);

    // Phase C: no idling; highest register values first, then a typical setting
    drain();
    snd_idle_pct  = 0;
    rcv_stall_pct = 0;
    write_cfg(ir_wlr_pkg::CFG_MIN_FIRST_PULSE, 16'hFFFF);
    write_cfg(ir_wlr_pkg::CFG_TIMEOUT_OVF, {rnd8(), 8'hFF});
    run_phase(100);
    drain();
    write_cfg(ir_wlr_pkg::CFG_MIN_FIRST_PULSE, ir_wlr_pkg::MIN_FIRST_PULSE_RST);
    write_cfg(ir_wlr_pkg::CFG_TIMEOUT_OVF, {rnd8(), 8'h03});
    run_phase(300);

    @(negedge clk);
    req_valid = 1'b0;

    // Wait out the outstanding results, bounded, then let the pipeline go quiet
    for (int w = 0; w < 20000 && pending != 0; w++) @(negedge clk);
    repeat (8) @(negedge clk);
    if (pending != 0) $display("%0t: %0d results never arrived", $time, pending);
    if (fails == 0 && pending == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
